[rtl/core/dtq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_pkg: shared types and codes of the deadline timer queue
// Slot layout, cell commands, status codes and input kind codes.
// ----------------------------------------------------------------------------
package dtq_pkg;

    localparam int ID_W  = 8;
    localparam int DL_W  = 48;
    localparam int PER_W = 32;
    localparam int MI_W  = 16;

    localparam logic [DL_W-1:0] DL_MAX           = {DL_W{1'b1}};
    localparam logic [MI_W-1:0] MIN_INTERVAL_RST = 16'd10;

    // input kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_STOP  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_TICK  = 2'd3;

    // result status codes
    localparam logic [2:0] ST_STARTED   = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_STOPPED   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FIRED     = 3'd4;
    localparam logic [2:0] ST_NONE_DUE  = 3'd5;
    localparam logic [2:0] ST_CLEARED   = 3'd6;

    // cell commands, broadcast to the whole chain
    localparam logic [2:0] OP_NOP    = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_POP    = 3'd2;
    localparam logic [2:0] OP_CLEAR  = 3'd3;
    localparam logic [2:0] OP_STOP   = 3'd4;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [DL_W-1:0]  deadline;
        logic [PER_W-1:0] period;
        logic             repeats;
        logic             to_main;
    } slot_t;

    typedef struct packed {
        logic  valid;
        slot_t slot;
    } entry_t;

    // stop token handed from cell to cell
    typedef struct packed {
        logic search;
        logic shift;
    } tok_t;

    typedef struct packed {
        logic [2:0] op;
        logic       probe;
        slot_t      slot;
    } cell_cmd_t;

    typedef struct packed {
        entry_t head;
        logic   last_valid;
        logic   found;
        logic   miss;
    } chain_stat_t;

endpackage

[rtl/core/dtq_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_cell: one slot of the sorted timer chain
// Holds one timer and trades it with its neighbors on insert, pop and stop.
// ----------------------------------------------------------------------------
module dtq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  dtq_pkg::cell_cmd_t cmd,
    input  dtq_pkg::entry_t    left_entry,
    input  logic               left_keep,
    input  dtq_pkg::entry_t    right_entry,
    input  dtq_pkg::tok_t      tok_in,
    output dtq_pkg::entry_t    entry,
    output logic               keep,
    output dtq_pkg::tok_t      tok_out,
    output logic               found,
    output logic               miss
);
    import dtq_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    slot_t slot_reg;
    slot_t slot_next;
    tok_t  tok_reg;
    tok_t  tok_next;

    assign entry.valid = valid_reg;
    assign entry.slot  = slot_reg;
    assign tok_out     = tok_reg;

    // this slot stays put when a new timer with this deadline goes in behind it
    assign keep = valid_reg && (slot_reg.deadline <= cmd.slot.deadline);

    always_comb
    begin
        valid_next = valid_reg;
        slot_next  = slot_reg;
        tok_next   = '0;
        found      = 1'b0;
        miss       = 1'b0;
        unique case (cmd.op)
            OP_INSERT:
            begin
                if (!keep)
                begin
                    if (left_keep)
                    begin
                        valid_next = 1'b1;
                        slot_next  = cmd.slot;
                    end
                    else
                    begin
                        valid_next = left_entry.valid;
                        slot_next  = left_entry.slot;
                    end
                end
            end
            OP_POP:
            begin
                valid_next = right_entry.valid;
                slot_next  = right_entry.slot;
            end
            OP_CLEAR:
            begin
                valid_next = 1'b0;
            end
            OP_STOP:
            begin
                if (tok_in.shift ||
                    (tok_in.search && valid_reg && slot_reg.id == cmd.slot.id))
                begin
                    // close the gap: pull the right neighbor in
                    valid_next = right_entry.valid;
                    slot_next  = right_entry.slot;
                    if (right_entry.valid)
                        tok_next.shift = 1'b1;
                    else
                        found = 1'b1;
                end
                else if (tok_in.search)
                begin
                    if (!valid_reg)
                        miss = 1'b1;
                    else
                        tok_next.search = 1'b1;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule

[rtl/core/dtq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_ctrl: command sequencer of the deadline timer queue
// Takes commands, drives the cell chain and produces the result transfers.
// ----------------------------------------------------------------------------
module dtq_ctrl #(
    parameter int MAX_FIRES_PER_TICK = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   kind,
    input  logic [dtq_pkg::ID_W-1:0]     timer_id,
    input  logic [dtq_pkg::DL_W-1:0]     deadline_ms,
    input  logic [dtq_pkg::PER_W-1:0]    period_ms,
    input  logic                         repeats,
    input  logic                         to_main,
    input  logic [dtq_pkg::DL_W-1:0]     now_ms,
    input  logic                         cfg_we,
    input  logic [dtq_pkg::MI_W-1:0]     cfg_wdata,
    input  dtq_pkg::chain_stat_t         stat,
    output dtq_pkg::cell_cmd_t           cmd,
    output logic                         result_valid,
    output logic [2:0]                   status,
    output logic [dtq_pkg::ID_W-1:0]     fired_id,
    output logic                         fired_to_main,
    output logic                         last
);
    import dtq_pkg::*;

    localparam int FIRE_W = $clog2(MAX_FIRES_PER_TICK + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_STOP  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_REINS = 3'd4;

    logic [2:0]        state_reg,      state_next;
    logic [1:0]        kind_reg,       kind_next;
    slot_t             slot_reg,       slot_next;
    logic [DL_W-1:0]   now_reg,        now_next;
    logic [MI_W-1:0]   mi_reg,         mi_next;
    logic [FIRE_W-1:0] fires_reg,      fires_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]   pend_id_reg,    pend_id_next;
    logic              pend_tm_reg,    pend_tm_next;
    logic              probe_reg,      probe_next;
    logic              res_valid_reg,  res_valid_next;
    logic [2:0]        res_status_reg, res_status_next;
    logic [ID_W-1:0]   res_id_reg,     res_id_next;
    logic              res_tm_reg,     res_tm_next;
    logic              res_last_reg,   res_last_next;

    logic [MI_W-1:0]   mi_eff;
    logic [PER_W-1:0]  step;
    logic [DL_W:0]     sum;
    logic [DL_W-1:0]   new_deadline;
    logic              due;

    assign busy          = (state_reg != S_IDLE);
    assign result_valid  = res_valid_reg;
    assign status        = res_status_reg;
    assign fired_id      = res_id_reg;
    assign fired_to_main = res_tm_reg;
    assign last          = res_last_reg;

    // next deadline of a recurring timer, saturating at the top of the range
    assign mi_eff       = (mi_reg == '0) ? MI_W'(1) : mi_reg;
    assign step         = (stat.head.slot.period < PER_W'(mi_eff)) ? PER_W'(mi_eff)
                                                                   : stat.head.slot.period;
    assign sum          = {1'b0, stat.head.slot.deadline} + (DL_W+1)'(step);
    assign new_deadline = sum[DL_W] ? DL_MAX : sum[DL_W-1:0];

    assign due = stat.head.valid && (stat.head.slot.deadline <= now_reg) &&
                 (fires_reg != FIRE_W'(MAX_FIRES_PER_TICK));

    assign mi_next = cfg_we ? cfg_wdata : mi_reg;

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        slot_next       = slot_reg;
        now_next        = now_reg;
        fires_next      = fires_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        pend_tm_next    = pend_tm_reg;
        probe_next      = 1'b0;
        res_valid_next  = 1'b0;
        res_status_next = res_status_reg;
        res_id_next     = '0;
        res_tm_next     = 1'b0;
        res_last_next   = 1'b1;
        cmd.op          = OP_NOP;
        cmd.probe       = probe_reg;
        cmd.slot        = slot_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next         = kind;
                    slot_next.id      = timer_id;
                    slot_next.deadline = deadline_ms;
                    slot_next.period  = period_ms;
                    slot_next.repeats = repeats;
                    slot_next.to_main = to_main;
                    now_next          = now_ms;
                    state_next        = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (kind_reg)
                    KIND_START:
                    begin
                        res_valid_next = 1'b1;
                        state_next     = S_IDLE;
                        if (stat.last_valid)
                            res_status_next = ST_FULL;
                        else
                        begin
                            cmd.op          = OP_INSERT;
                            res_status_next = ST_STARTED;
                        end
                    end
                    KIND_STOP:
                    begin
                        probe_next = 1'b1;
                        state_next = S_STOP;
                    end
                    KIND_CLEAR:
                    begin
                        cmd.op          = OP_CLEAR;
                        res_valid_next  = 1'b1;
                        res_status_next = ST_CLEARED;
                        state_next      = S_IDLE;
                    end
                    default:
                    begin
                        fires_next      = '0;
                        pend_valid_next = 1'b0;
                        state_next      = S_CHECK;
                    end
                endcase
            end
            S_STOP:
            begin
                cmd.op = OP_STOP;
                if (stat.found || stat.miss)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = stat.found ? ST_STOPPED : ST_NOT_FOUND;
                    state_next      = S_IDLE;
                end
            end
            S_CHECK:
            begin
                if (due)
                begin
                    cmd.op = OP_POP;
                    // the previous fire is not the final one
                    if (pend_valid_reg)
                    begin
                        res_valid_next  = 1'b1;
                        res_status_next = ST_FIRED;
                        res_id_next     = pend_id_reg;
                        res_tm_next     = pend_tm_reg;
                        res_last_next   = 1'b0;
                    end
                    pend_valid_next    = 1'b1;
                    pend_id_next       = stat.head.slot.id;
                    pend_tm_next       = stat.head.slot.to_main;
                    fires_next         = fires_reg + FIRE_W'(1);
                    slot_next          = stat.head.slot;
                    slot_next.deadline = new_deadline;
                    state_next         = stat.head.slot.repeats ? S_REINS : S_CHECK;
                end
                else
                begin
                    res_valid_next = 1'b1;
                    if (pend_valid_reg)
                    begin
                        res_status_next = ST_FIRED;
                        res_id_next     = pend_id_reg;
                        res_tm_next     = pend_tm_reg;
                    end
                    else
                        res_status_next = ST_NONE_DUE;
                    state_next = S_IDLE;
                end
            end
            S_REINS:
            begin
                // the popped slot left room, so this always fits
                cmd.op     = OP_INSERT;
                state_next = S_CHECK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mi_reg         <= MIN_INTERVAL_RST;
            fires_reg      <= '0;
            pend_valid_reg <= 1'b0;
            probe_reg      <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mi_reg         <= mi_next;
            fires_reg      <= fires_next;
            pend_valid_reg <= pend_valid_next;
            probe_reg      <= probe_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        slot_reg       <= slot_next;
        now_reg        <= now_next;
        pend_id_reg    <= pend_id_next;
        pend_tm_reg    <= pend_tm_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_tm_reg     <= res_tm_next;
        res_last_reg   <= res_last_next;
    end

endmodule

[rtl/core/deadline_timer_queue_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_timer_queue_top: sorted deadline timer queue
// Timers kept in deadline order in a chain of slot cells, fired by ticks.
// ----------------------------------------------------------------------------
//  channel   | handshake              | payload
//  ----------+------------------------+----------------------------------------
//  command   | start / busy           | kind timer_id deadline_ms period_ms
//            |                        | repeats to_main now_ms
//  config    | cfg_we                 | cfg_wdata (min_interval_ms)
//  result    | result_valid (strobe)  | status fired_id fired_to_main last
//
//  start and clear give their result after the execute state; a stop ends
//  when the token walking the cell chain one slot a cycle has closed the
//  gap behind the matching id or has missed it. A tick pops each fired
//  timer and reinserts each recurring one, each a single pass over the chain.
//  Reset empties the queue and loads min_interval_ms with 10.
//  Results cannot be stalled: each shows for one cycle under result_valid.
// ----------------------------------------------------------------------------
module deadline_timer_queue_top #(
    parameter int QUEUE_DEPTH        = 16,
    parameter int MAX_FIRES_PER_TICK = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   kind,
    input  logic [dtq_pkg::ID_W-1:0]     timer_id,
    input  logic [dtq_pkg::DL_W-1:0]     deadline_ms,
    input  logic [dtq_pkg::PER_W-1:0]    period_ms,
    input  logic                         repeats,
    input  logic                         to_main,
    input  logic [dtq_pkg::DL_W-1:0]     now_ms,
    input  logic                         cfg_we,
    input  logic [dtq_pkg::MI_W-1:0]     cfg_wdata,
    output logic                         result_valid,
    output logic [2:0]                   status,
    output logic [dtq_pkg::ID_W-1:0]     fired_id,
    output logic                         fired_to_main,
    output logic                         last
);
    import dtq_pkg::*;

    cell_cmd_t              cmd;
    chain_stat_t            stat;
    entry_t                 ent   [QUEUE_DEPTH];
    tok_t                   tok   [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] keep_v;
    logic [QUEUE_DEPTH-1:0] found_v;
    logic [QUEUE_DEPTH-1:0] miss_v;
    logic [QUEUE_DEPTH-1:0] valid_v;

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            entry_t left_e;
            entry_t right_e;
            logic   left_k;
            tok_t   tin;

            if (i == 0)
            begin : g_head
                assign left_e     = '0;
                assign left_k     = 1'b1;
                assign tin.search = cmd.probe;
                assign tin.shift  = 1'b0;
            end
            else
            begin : g_body
                assign left_e = ent[i-1];
                assign left_k = keep_v[i-1];
                assign tin    = tok[i-1];
            end

            if (i == QUEUE_DEPTH - 1)
            begin : g_tail
                assign right_e = '0;
            end
            else
            begin : g_inner
                assign right_e = ent[i+1];
            end

            dtq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .left_entry  (left_e),
                .left_keep   (left_k),
                .right_entry (right_e),
                .tok_in      (tin),
                .entry       (ent[i]),
                .keep        (keep_v[i]),
                .tok_out     (tok[i]),
                .found       (found_v[i]),
                .miss        (miss_v[i])
            );

            assign valid_v[i] = ent[i].valid;
        end
    endgenerate

    // a search token leaving the tail means no slot matched
    assign stat.head       = ent[0];
    assign stat.last_valid = ent[QUEUE_DEPTH-1].valid;
    assign stat.found      = |found_v;
    assign stat.miss       = (|miss_v) || tok[QUEUE_DEPTH-1].search;

    dtq_ctrl #(
        .MAX_FIRES_PER_TICK (MAX_FIRES_PER_TICK)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .timer_id      (timer_id),
        .deadline_ms   (deadline_ms),
        .period_ms     (period_ms),
        .repeats       (repeats),
        .to_main       (to_main),
        .now_ms        (now_ms),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .stat          (stat),
        .cmd           (cmd),
        .result_valid  (result_valid),
        .status        (status),
        .fired_id      (fired_id),
        .fired_to_main (fired_to_main),
        .last          (last)
    );

    // occupied slots always form a prefix from the head
    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_v & (valid_v + QUEUE_DEPTH'(1))) == '0)
        else $error("occupied slots are not a prefix");

    // the two head slots stay in deadline order
    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        ent[1].valid |-> (ent[0].slot.deadline <= ent[1].slot.deadline))
        else $error("head slots out of deadline order");

    a_stop_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(stat.found && stat.miss))
        else $error("stop found and missed at once");

    // only fires can be followed by more results of the same command
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status != ST_FIRED) |-> last)
        else $error("non-fire result without last");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |-> !busy)
        else $error("final result while still busy");

endmodule
